[rtl/lrol_pkg.sv]
// lrol_pkg: shared widths, constants and beat structs for the lagged ring overlap-add
// used by every module of the block, no dependencies
package lrol_pkg;

    localparam int CHAN_W     = 6;
    localparam int IDX_W      = 10;
    localparam int RSLOT_W    = 10;
    localparam int DATA_W     = 32;
    localparam int CL_W       = 10;
    localparam int OUT_ADDR_W = 10;
    localparam int CHAN_SPAN  = 1 << CHAN_W;
    localparam int MAX_IDX    = (1 << IDX_W) - 1;

    localparam logic [CL_W-1:0] CL_RESET = CL_W'(256);

    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = 2;
    localparam int OQ_CNT_W = 3;

    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic                     valid;
        logic                     rd;
        logic                     acc;
        logic                     err;
        logic signed [DATA_W-1:0] sample;
        logic [OUT_ADDR_W-1:0]    slot_address;
        logic [OUT_ADDR_W-1:0]    pointer_after;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] slot_value;
        logic [OUT_ADDR_W-1:0]    slot_address;
        logic [OUT_ADDR_W-1:0]    pointer_after;
        logic                     saturated;
        logic                     index_error;
    } res_t;

endpackage

[rtl/lrol_front.sv]
// lrol_front: write pointer, input stage and ring address computation
// depends on lrol_pkg
module lrol_front #(
    parameter int CHANNELS   = 64,
    parameter int RING_DEPTH = 1024,
    parameter int CH_W       = 6,
    parameter int SLOT_W     = 10
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             accept,
    input  logic                             mode,
    input  logic [lrol_pkg::CHAN_W-1:0]      channel,
    input  logic [lrol_pkg::IDX_W-1:0]       chunk_index,
    input  logic [lrol_pkg::RSLOT_W-1:0]     ring_slot,
    input  logic signed [lrol_pkg::DATA_W-1:0] sample_value,
    input  logic                             end_of_chunk,
    input  logic [lrol_pkg::CL_W-1:0]        chunk_len,
    output lrol_pkg::req_t                   req,
    output logic [CH_W+SLOT_W-1:0]           req_addr
);

    localparam int CHOFF    = RING_DEPTH * ((lrol_pkg::CHAN_SPAN + RING_DEPTH - 1) / RING_DEPTH);
    localparam int RED_MAX  = (RING_DEPTH - 1) + lrol_pkg::MAX_IDX + CHOFF;
    localparam int RED_W    = $clog2(RED_MAX + 1);
    localparam int MULT_MAX = RED_MAX / RING_DEPTH;
    localparam int KS       = $clog2(MULT_MAX + 1);
    localparam int CMP_W    = 17;

    function automatic logic [SLOT_W-1:0] ring_mod(input logic [RED_W-1:0] x);
        logic [RED_W-1:0] r;
        r = x;
        for (int k = KS - 1; k >= 0; k--) begin
            if (r >= (RED_W'(RING_DEPTH) << k)) begin
                r = r - (RED_W'(RING_DEPTH) << k);
            end
        end
        return SLOT_W'(r);
    endfunction

    logic [SLOT_W-1:0]                wp_reg, wp_next;
    logic                             s1_valid_reg;
    logic                             s1_mode_reg;
    logic [lrol_pkg::CHAN_W-1:0]      s1_chan_reg;
    logic [lrol_pkg::IDX_W-1:0]       s1_idx_reg;
    logic [lrol_pkg::RSLOT_W-1:0]     s1_rslot_reg;
    logic signed [lrol_pkg::DATA_W-1:0] s1_sample_reg;
    logic [SLOT_W-1:0]                s1_wp_reg;

    logic [SLOT_W-1:0] slot;
    logic              chan_bad;
    logic              idx_bad;
    logic              rslot_bad;
    logic              err;

    always_comb begin
        wp_next = wp_reg;
        if (accept && !mode && end_of_chunk) begin
            wp_next = ring_mod(RED_W'(wp_reg) + RED_W'(chunk_len));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg       <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            wp_reg       <= wp_next;
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_mode_reg   <= mode;
            s1_chan_reg   <= channel;
            s1_idx_reg    <= chunk_index;
            s1_rslot_reg  <= ring_slot;
            s1_sample_reg <= sample_value;
            s1_wp_reg     <= wp_reg;
        end
    end

    always_comb begin
        slot = ring_mod(RED_W'(s1_wp_reg) + RED_W'(s1_idx_reg) + RED_W'(CHOFF)
                        - RED_W'(s1_chan_reg));
        chan_bad  = (11'(s1_chan_reg) >= 11'(CHANNELS));
        idx_bad   = (11'(s1_idx_reg) >= (11'(chunk_len) + 11'(s1_chan_reg)));
        rslot_bad = (CMP_W'(s1_rslot_reg) >= CMP_W'(RING_DEPTH));
        err       = s1_mode_reg ? (chan_bad || rslot_bad) : (chan_bad || idx_bad);

        req.valid         = s1_valid_reg;
        req.rd            = s1_mode_reg;
        req.acc           = !s1_mode_reg && (11'(s1_idx_reg) < 11'(s1_chan_reg));
        req.err           = err;
        req.sample        = s1_sample_reg;
        req.pointer_after = lrol_pkg::OUT_ADDR_W'(wp_reg);
        if (s1_mode_reg) begin
            req.slot_address = s1_rslot_reg;
            req_addr         = {CH_W'(s1_chan_reg), SLOT_W'(s1_rslot_reg)};
        end else begin
            req.slot_address = err ? '0 : lrol_pkg::OUT_ADDR_W'(slot);
            req_addr         = {CH_W'(s1_chan_reg), slot};
        end
    end

endmodule

[rtl/lrol_ring.sv]
// lrol_ring: ring memory with clearing pass, read-modify-write stage and forwarding
// depends on lrol_pkg
module lrol_ring #(
    parameter int ADDR_W = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lrol_pkg::req_t        req,
    input  logic [ADDR_W-1:0]     req_addr,
    output logic                  clr_done,
    output logic                  res_valid,
    output lrol_pkg::res_t        res
);

    localparam int MEM_DEPTH = 1 << ADDR_W;

    logic [lrol_pkg::DATA_W-1:0] mem [MEM_DEPTH];

    logic [ADDR_W:0]             clr_reg, clr_next;
    lrol_pkg::req_t              s2_reg;
    logic [ADDR_W-1:0]           s2_addr_reg;
    logic [lrol_pkg::DATA_W-1:0] rdata_reg;
    logic                        fwd_hit_reg, fwd_hit_next;
    logic [lrol_pkg::DATA_W-1:0] fwd_data_reg;

    logic signed [lrol_pkg::DATA_W-1:0] old_val;
    logic signed [lrol_pkg::DATA_W:0]   sum;
    logic                               ovf;
    logic signed [lrol_pkg::DATA_W-1:0] acc_val;
    logic signed [lrol_pkg::DATA_W-1:0] wr_val;
    logic                               item_we;
    logic                               mem_we;
    logic [ADDR_W-1:0]                  mem_wa;
    logic [lrol_pkg::DATA_W-1:0]        mem_wd;

    assign clr_done = clr_reg[ADDR_W];
    assign clr_next = clr_done ? clr_reg : clr_reg + 1'b1;

    always_comb begin
        old_val = fwd_hit_reg ? fwd_data_reg : rdata_reg;
        sum     = {old_val[lrol_pkg::DATA_W-1], old_val}
                + {s2_reg.sample[lrol_pkg::DATA_W-1], s2_reg.sample};
        ovf     = (sum[lrol_pkg::DATA_W] != sum[lrol_pkg::DATA_W-1]);
        if (ovf) begin
            acc_val = sum[lrol_pkg::DATA_W] ? lrol_pkg::SAT_MIN : lrol_pkg::SAT_MAX;
        end else begin
            acc_val = sum[lrol_pkg::DATA_W-1:0];
        end
        wr_val  = s2_reg.acc ? acc_val : s2_reg.sample;
        item_we = s2_reg.valid && !s2_reg.rd && !s2_reg.err;

        mem_we = !clr_done || item_we;
        mem_wa = clr_done ? s2_addr_reg : clr_reg[ADDR_W-1:0];
        mem_wd = clr_done ? wr_val : '0;

        fwd_hit_next = req.valid && item_we && (s2_addr_reg == req_addr);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg      <= '0;
            s2_reg.valid <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end else begin
            clr_reg      <= clr_next;
            s2_reg.valid <= req.valid;
            fwd_hit_reg  <= fwd_hit_next;
        end
        s2_reg.rd            <= req.rd;
        s2_reg.acc           <= req.acc;
        s2_reg.err           <= req.err;
        s2_reg.sample        <= req.sample;
        s2_reg.slot_address  <= req.slot_address;
        s2_reg.pointer_after <= req.pointer_after;
        s2_addr_reg          <= req_addr;
        fwd_data_reg         <= wr_val;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[req_addr];
    end

    always_comb begin
        res_valid         = s2_reg.valid;
        res.slot_address  = s2_reg.slot_address;
        res.pointer_after = s2_reg.pointer_after;
        res.index_error   = s2_reg.err;
        res.saturated     = item_we && s2_reg.acc && ovf;
        if (s2_reg.err) begin
            res.slot_value = '0;
        end else if (s2_reg.rd) begin
            res.slot_value = old_val;
        end else begin
            res.slot_value = wr_val;
        end
    end

    a_no_item_during_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_reg.valid |-> clr_done)
        else $error("item reached the ring during the clearing pass");

    a_sat_only_on_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.saturated) |-> (s2_reg.acc && !s2_reg.err && !s2_reg.rd))
        else $error("saturation flagged outside an accumulate");

    a_err_write_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.index_error && !s2_reg.rd) |->
        (res.slot_value == '0 && res.slot_address == '0))
        else $error("ignored sample reported a nonzero slot");

    a_fwd_after_write: assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_hit_reg |-> $past(item_we))
        else $error("forward hit without a write in the previous cycle");

endmodule

[rtl/lrol_outq.sv]
// lrol_outq: small result queue that decouples the ring pipeline from the receiver
// depends on lrol_pkg
module lrol_outq (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           push,
    input  lrol_pkg::res_t                 push_data,
    input  logic                           pop,
    output logic                           not_empty,
    output lrol_pkg::res_t                 head,
    output logic [lrol_pkg::OQ_CNT_W-1:0]  count
);

    lrol_pkg::res_t                   q_mem [lrol_pkg::OQ_DEPTH];
    logic [lrol_pkg::OQ_PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [lrol_pkg::OQ_CNT_W-1:0]    cnt_reg, cnt_next;
    logic                             do_pop;

    assign not_empty = (cnt_reg != '0);
    assign head      = q_mem[rd_ptr_reg];
    assign count     = cnt_reg;
    assign do_pop    = pop && not_empty;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!push && do_pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/lagged_ring_overlap_add.sv]
// lagged_ring_overlap_add: top level of the dedispersion ring-buffer update
// depends on lrol_pkg, lrol_front, lrol_ring, lrol_outq
//
// Input beats on s_*: tuser selects a write sample (0) or a slot read (1), tlast marks
// the last sample of a chunk and moves the shared write pointer by the chunk size.
// Every input beat yields exactly one result beat on m_*, in order.
// The cfg_* channel writes the chunk size; it is always ready. The user must write it
// only while the block is idle; the block itself does not enforce this.
// An accepted beat passes the input stage, the ring stage and the result queue
// before it is offered on m_*. Throughput is one beat per cycle while s_tready is
// high: one ring memory read per beat and one write per error-free write beat, with
// the previous beat's write forwarded when both hit one entry. After reset the ring
// memory is swept to zero, one entry per cycle, over all 2**(clog2(CHANNELS) +
// clog2(RING_DEPTH)) entries (65536 at the defaults); s_tready stays low during the
// sweep. A stalled receiver fills a four-entry result queue; s_tready falls once the
// queue and the two pipeline stages hold four beats between them, so nothing is
// lost and the block resumes at full rate when m_tready returns.
module lagged_ring_overlap_add #(
    parameter int CHANNELS   = 64,
    parameter int RING_DEPTH = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // channel, chunk_index, ring_slot, sample_value
    input  logic        s_tuser,  // mode
    input  logic        s_tlast,  // end_of_chunk
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,  // slot_value, slot_address, pointer_after
    output logic [1:0]  m_tuser,  // saturated, index_error
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [9:0]  cfg_data  // chunk size
);

    localparam int CH_W   = $clog2(CHANNELS);
    localparam int SLOT_W = $clog2(RING_DEPTH);
    localparam int ADDR_W = CH_W + SLOT_W;

    logic [lrol_pkg::CL_W-1:0]        cl_reg, cl_next;
    logic                             accept;
    lrol_pkg::req_t                   req;
    logic [ADDR_W-1:0]                req_addr;
    logic                             clr_done;
    logic                             res_valid;
    lrol_pkg::res_t                   res;
    lrol_pkg::res_t                   head;
    logic [lrol_pkg::OQ_CNT_W-1:0]    q_count;
    logic [lrol_pkg::OQ_CNT_W-1:0]    occupancy;

    assign cfg_ready = 1'b1;
    assign cl_next   = (cfg_valid && cfg_ready) ? cfg_data : cl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cl_reg <= lrol_pkg::CL_RESET;
        end else begin
            cl_reg <= cl_next;
        end
    end

    assign occupancy = q_count + lrol_pkg::OQ_CNT_W'(req.valid)
                     + lrol_pkg::OQ_CNT_W'(res_valid);
    assign s_tready  = clr_done && (occupancy < lrol_pkg::OQ_CNT_W'(lrol_pkg::OQ_DEPTH));
    assign accept    = s_tvalid && s_tready;

    lrol_front #(
        .CHANNELS   (CHANNELS),
        .RING_DEPTH (RING_DEPTH),
        .CH_W       (CH_W),
        .SLOT_W     (SLOT_W)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .mode         (s_tuser),
        .channel      (s_tdata[5:0]),
        .chunk_index  (s_tdata[15:6]),
        .ring_slot    (s_tdata[25:16]),
        .sample_value (s_tdata[57:26]),
        .end_of_chunk (s_tlast),
        .chunk_len    (cl_reg),
        .req          (req),
        .req_addr     (req_addr)
    );

    lrol_ring #(
        .ADDR_W (ADDR_W)
    ) u_ring (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (req),
        .req_addr  (req_addr),
        .clr_done  (clr_done),
        .res_valid (res_valid),
        .res       (res)
    );

    lrol_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .pop       (m_tready),
        .not_empty (m_tvalid),
        .head      (head),
        .count     (q_count)
    );

    assign m_tdata = {4'd0, head.pointer_after, head.slot_address, head.slot_value};
    assign m_tuser = {head.index_error, head.saturated};

endmodule
